// ===== sv/ltpy_pkg.sv =====
// ----------------------------------------------------------------------------
// ltpy_pkg
// Shared constants, sequencer states and the divider command type for the
// life-table person-years unit.
// ----------------------------------------------------------------------------
package ltpy_pkg;

  // default data width of the Q(W-16).16 fields
  localparam int DATA_WIDTH_DEF = 32;

  // survivorship lx is unsigned Q1.31
  localparam int          LX_W   = 32;
  localparam logic [31:0] LX_ONE = 32'h8000_0000;

  // 1.0 in the Q.32 scale of the qx numerator and denominator
  localparam int ONE_SHIFT = 32;

  // quotient register of the shared divider: 2*lx / mx needs 33 bits
  localparam int QUO_W = 33;

  // divider step counts
  localparam int ROW_STEPS  = 31;
  localparam int LAST_STEPS = 33;
  localparam int STEP_W     = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_CHECK,
    ST_DIV_ROW,
    ST_MUL_NEXT,
    ST_MUL_L1,
    ST_MUL_L2,
    ST_DIV_LAST,
    ST_FINISH
  } state_e;

  // divider launch command
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

endpackage

// ===== sv/ltpy_if.sv =====
// ----------------------------------------------------------------------------
// ltpy_in_if / ltpy_out_if
// Valid/ready channels carrying one age-group item in and one result item out.
// ----------------------------------------------------------------------------
interface ltpy_in_if #(
  parameter int DW = 32
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] rate;
  logic [DW-1:0] mean_time_dying;
  logic [DW-1:0] interval_width;
  logic          last_age;

  modport source (output valid, rate, mean_time_dying, interval_width, last_age,
                  input ready);
  modport sink   (input valid, rate, mean_time_dying, interval_width, last_age,
                  output ready);
endinterface

interface ltpy_out_if #(
  parameter int DW = 32
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] person_years;
  logic          divide_error;

  modport source (output valid, person_years, divide_error, input ready);
  modport sink   (input valid, person_years, divide_error, output ready);
endinterface

// ===== sv/life_table_person_years_unit.sv =====
// ----------------------------------------------------------------------------
// life_table_person_years_unit
// Person-years Lx per age group from mx, ax, nx, keeping survivorship lx.
// Ordinary row: five multiplier passes (MW = max(DATA_WIDTH,32)) plus a
//   31-step divide; the divide is skipped when qx clamps to one, and a bad
//   divisor ends the row after the denominator pass with a divide error.
// Open final row: 33-step divide; zero rate: no divide, divide error.
// One item at a time; the next item is taken while the result waits.
// Reset: lx = 1.0, output empty; no clearing pass.
// ----------------------------------------------------------------------------
module life_table_person_years_unit #(
  parameter int DATA_WIDTH = ltpy_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltpy_in_if.sink     in_i,
  ltpy_out_if.source  out_o
);
  import ltpy_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int MW  = (W > LX_W) ? W : LX_W;
  localparam int NW  = 2 * W;
  localparam int DNW = NW + 1;
  localparam int PW  = 2 * MW;
  localparam int LW  = W + LX_W;
  localparam int SW  = LW + 1;
  localparam int ZW  = QUO_W + W;

  state_e state_q, state_d;

  logic [W-1:0]     m_q, a_q, n_q, diff_na, py_row, py_last;
  logic             last_q, n_ge_a, bad_q, bad_w;
  logic [LX_W-1:0]  lx_q, next_q, next_w, q_src, one_m_q, lx_m_next;
  logic [NW-1:0]    num_q;
  logic [DNW-1:0]   den_q, den_w, one_sc, t_ext;
  logic [LW-1:0]    p1_q;
  logic [SW-1:0]    sum_w;
  logic [ZW-1:0]    quot_z;
  logic [W-1:0]     res_py_q;
  logic             res_err_q;
  logic             out_valid_q;
  logic [W-1:0]     out_py_q;
  logic             out_err_q;
  logic             accept, out_free;

  logic             mul_start, mul_done;
  logic [MW-1:0]    mul_a, mul_b;
  logic [PW-1:0]    mul_prod;
  div_cmd_t         div_cmd;
  logic [DNW-1:0]   div_rem, div_dsr;
  logic [QUO_W-1:0] div_dvd, div_quot;
  logic             div_done;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // arithmetic around the shared units
  assign n_ge_a    = n_q >= a_q;
  assign diff_na   = n_ge_a ? n_q - a_q : a_q - n_q;
  assign one_sc    = DNW'(1) << ONE_SHIFT;
  assign t_ext     = DNW'(mul_prod[NW-1:0]);
  assign bad_w     = !n_ge_a && (t_ext >= one_sc);
  assign den_w     = n_ge_a ? one_sc + t_ext : one_sc - t_ext;
  assign q_src     = (state_q == ST_DIV_ROW) ? {1'b0, div_quot[ROW_STEPS-1:0]} : LX_ONE;
  assign one_m_q   = LX_ONE - q_src;
  assign next_w    = mul_prod[2*LX_W-2:LX_W-1];
  assign lx_m_next = lx_q - next_q;
  assign sum_w     = SW'(p1_q) + SW'(mul_prod[LW-1:0]);
  assign py_row    = (|sum_w[SW-1:SW-2]) ? '1 : sum_w[W+LX_W-2:LX_W-1];
  assign quot_z    = ZW'(div_quot);
  assign py_last   = (quot_z > ZW'({W{1'b1}})) ? '1 : quot_z[W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!in_i.last_age) state_d = ST_MUL_NUM;
          else if (in_i.rate[W-1:0] == '0) state_d = ST_FINISH;
          else state_d = ST_DIV_LAST;
        end
      end
      ST_MUL_NUM:  if (mul_done) state_d = ST_MUL_DEN;
      ST_MUL_DEN:  if (mul_done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (bad_q) state_d = ST_FINISH;
        else if (DNW'(num_q) >= den_q) state_d = ST_MUL_NEXT;
        else state_d = ST_DIV_ROW;
      end
      ST_DIV_ROW:  if (div_done) state_d = ST_MUL_NEXT;
      ST_MUL_NEXT: if (mul_done) state_d = ST_MUL_L1;
      ST_MUL_L1:   if (mul_done) state_d = ST_MUL_L2;
      ST_MUL_L2:   if (mul_done) state_d = ST_FINISH;
      ST_DIV_LAST: if (div_done) state_d = ST_FINISH;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // unit launches on state entry
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_cmd   = '0;
    div_rem   = '0;
    div_dvd   = '0;
    div_dsr   = '0;
    if (state_d != state_q) begin
      case (state_d)
        ST_MUL_NUM: begin
          mul_start = 1'b1;
          mul_a     = MW'(in_i.interval_width[W-1:0]);
          mul_b     = MW'(in_i.rate[W-1:0]);
        end
        ST_MUL_DEN: begin
          mul_start = 1'b1;
          mul_a     = MW'(diff_na);
          mul_b     = MW'(m_q);
        end
        ST_MUL_NEXT: begin
          mul_start = 1'b1;
          mul_a     = MW'(lx_q);
          mul_b     = MW'(one_m_q);
        end
        ST_MUL_L1: begin
          mul_start = 1'b1;
          mul_a     = MW'(next_w);
          mul_b     = MW'(n_q);
        end
        ST_MUL_L2: begin
          mul_start = 1'b1;
          mul_a     = MW'(lx_m_next);
          mul_b     = MW'(a_q);
        end
        ST_DIV_ROW: begin
          div_cmd.start = 1'b1;
          div_cmd.steps = STEP_W'(ROW_STEPS);
          div_rem       = DNW'(num_q);
          div_dsr       = den_q;
        end
        ST_DIV_LAST: begin
          div_cmd.start = 1'b1;
          div_cmd.steps = STEP_W'(LAST_STEPS);
          div_dvd       = {lx_q, 1'b0};
          div_dsr       = DNW'(in_i.rate[W-1:0]);
        end
        default: ;
      endcase
    end
  end

  ltpy_multiplier #(.MW(MW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ltpy_divider #(.DNW(DNW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .rem_i      (div_rem),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lx_q        <= LX_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE:     if (accept && in_i.last_age && in_i.rate[W-1:0] == '0) lx_q <= LX_ONE;
        ST_CHECK:    if (bad_q) lx_q <= '0;
        ST_MUL_L2:   if (mul_done) lx_q <= next_q;
        ST_DIV_LAST: if (div_done) lx_q <= LX_ONE;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          m_q       <= in_i.rate[W-1:0];
          a_q       <= in_i.mean_time_dying[W-1:0];
          n_q       <= in_i.interval_width[W-1:0];
          last_q    <= in_i.last_age;
          res_py_q  <= '1;
          res_err_q <= 1'b1;
        end
      end
      ST_MUL_NUM: if (mul_done) num_q <= mul_prod[NW-1:0];
      ST_MUL_DEN: begin
        if (mul_done) begin
          den_q <= den_w;
          bad_q <= bad_w;
        end
      end
      ST_MUL_NEXT: if (mul_done) next_q <= next_w;
      ST_MUL_L1:   if (mul_done) p1_q <= mul_prod[LW-1:0];
      ST_MUL_L2: begin
        if (mul_done) begin
          res_py_q  <= py_row;
          res_err_q <= 1'b0;
        end
      end
      ST_DIV_LAST: begin
        if (div_done) begin
          res_py_q  <= py_last;
          res_err_q <= 1'b0;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_py_q  <= res_py_q;
          out_err_q <= res_err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.person_years = out_py_q;
  assign out_o.divide_error = out_err_q;

  a_lx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lx_q <= LX_ONE)
    else $error("survivorship above 1.0");

  a_err_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && res_err_q |-> res_py_q == '1)
    else $error("divide error without saturated person-years");

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL_NUM || state_q == ST_MUL_DEN ||
                  state_q == ST_MUL_NEXT || state_q == ST_MUL_L1 ||
                  state_q == ST_MUL_L2))
    else $error("multiplier finished outside a multiply step");

  a_last_resets_lx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && last_q |-> lx_q == LX_ONE)
    else $error("open row did not restore survivorship");

endmodule

// ===== sv/ltpy_multiplier.sv =====
// ----------------------------------------------------------------------------
// ltpy_multiplier
// Bit-serial shift-add multiplier: one multiplier bit per cycle, MW bits.
// ----------------------------------------------------------------------------
module ltpy_multiplier #(
  parameter int MW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MW-1:0]   a_i,
  input  logic [MW-1:0]   b_i,
  output logic            done_o,
  output logic [2*MW-1:0] prod_o
);
  localparam int CW = $clog2(MW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [MW-1:0] a_q, hi_q, lo_q, hi_d, lo_d;
  logic [MW:0]   sum;

  // add the multiplicand into the upper half, then shift right one bit
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  assign {hi_d, lo_d} = {sum, lo_q[MW-1:1]};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(MW);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (cnt_q != '0) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

  a_done_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("multiplier done while still stepping");

  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == CW'(MW))
    else $error("multiplier count not loaded on start");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held longer than one cycle");

endmodule

// ===== sv/ltpy_divider.sv =====
// ----------------------------------------------------------------------------
// ltpy_divider
// Restoring radix-2 divider: one quotient bit per cycle, shared between the
// qx quotient and the open-row lx/mx quotient.
// ----------------------------------------------------------------------------
module ltpy_divider #(
  parameter int DNW = 65
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ltpy_pkg::div_cmd_t        cmd_i,
  input  logic [DNW-1:0]            rem_i,
  input  logic [ltpy_pkg::QUO_W-1:0] dividend_i,
  input  logic [DNW-1:0]            divisor_i,
  output logic                      done_o,
  output logic [ltpy_pkg::QUO_W-1:0] quot_o
);
  import ltpy_pkg::*;

  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DNW-1:0]    rem_q, dsr_q, rem_d;
  logic [QUO_W-1:0]  dvd_q, quo_q;
  logic [DNW:0]      shifted, diff;
  logic              ge;

  // bring down the next dividend bit, trial subtract
  assign shifted = {rem_q, dvd_q[QUO_W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};
  assign rem_d   = ge ? diff[DNW-1:0] : shifted[DNW-1:0];

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      cnt_d = cmd_i.steps;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= rem_i;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && !cmd_i.start |=> rem_q < dsr_q)
    else $error("divider remainder not below divisor");

  a_done_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == '0)
    else $error("divider done while still stepping");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");

endmodule
